FILE: rtl/assert_macros.svh
// Shared assertion macros for the frame command generator checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lmfcg_pkg.sv
`default_nettype none

package lmfcg_pkg;

    localparam int ROW_COUNT_DEF = 8;

    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 8;
    localparam int IDX_W      = 4;
    localparam int COL_W      = 4;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_ON = 2'd2;

    // Driver register addresses
    localparam logic [ADDR_W-1:0] ADDR_DECODE    = 4'd9;
    localparam logic [ADDR_W-1:0] ADDR_INTENSITY = 4'd10;
    localparam logic [ADDR_W-1:0] ADDR_SCAN      = 4'd11;
    localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN  = 4'd12;
    localparam logic [ADDR_W-1:0] ADDR_TEST      = 4'd15;

    localparam logic [DATA_W-1:0] TOP_BIT = 8'h80;

    // Writes in the settings sequence
    localparam int SET_STEPS = 5;

    typedef enum logic [2:0] {
        ACT_PIXEL    = 3'd0,
        ACT_ROW_BYTE = 3'd1,
        ACT_LINE     = 3'd2,
        ACT_SCROLL   = 3'd3,
        ACT_CLEAR    = 3'd4,
        ACT_REFRESH  = 3'd5,
        ACT_SETTINGS = 3'd6
    } t_action;

endpackage

`default_nettype wire

FILE: rtl/lmfcg_ram.sv
`default_nettype none

module lmfcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/led_matrix_frame_command_gen_unit.sv
// Path: an accepted item is read from the frame RAM into its read register, modified,
// and held in the output register; a new item is not taken until the last write of the
// current one has left the modify stage (scroll, clear, refresh or a line write every row).
// Rate is set by the frame RAM: one row read and one row write per cycle while the output is not stalled.
// Reset: synchronous, active low; loads the frame RAM with zeros, row by row,
// before the first input is taken.
`default_nettype none

module led_matrix_frame_command_gen_unit
    import lmfcg_pkg::*;
#(
    parameter int ROW_COUNT = ROW_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [3:0] index, [7:4] column, [8] pixel_on, [16:9] value, [23:17] zero
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [2:0] action
    input  wire logic [S_TUSER_W-1:0]  i_s_axis_tuser,
    // output stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [3:0] reg_address, [11:4] reg_data
    output logic      [M_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                       o_m_axis_tlast
);

    localparam int ROW_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int N_MAX  = (ROW_COUNT > SET_STEPS) ? ROW_COUNT : SET_STEPS;
    localparam int STEP_W = $clog2(N_MAX + 1);
    localparam logic [STEP_W-1:0] ROWS_N   = STEP_W'(ROW_COUNT);
    localparam logic [STEP_W-1:0] SETS_N   = STEP_W'(SET_STEPS);
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);

    // configuration registers
    logic [3:0] r_intensity;
    logic [2:0] r_scan_limit;
    logic       r_shutdown_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intensity   <= 4'd0;
            r_scan_limit  <= 3'd7;
            r_shutdown_on <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INTENSITY:   r_intensity   <= i_cfg_data[3:0];
                CFG_SCAN_LIMIT:  r_scan_limit  <= i_cfg_data[2:0];
                CFG_SHUTDOWN_ON: r_shutdown_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [IDX_W-1:0]  w_in_idx;
    logic [COL_W-1:0]  w_in_col;
    logic              w_in_on;
    logic [DATA_W-1:0] w_in_val;

    assign w_in_idx = i_s_axis_tdata[3:0];
    assign w_in_col = i_s_axis_tdata[7:4];
    assign w_in_on  = i_s_axis_tdata[8];
    assign w_in_val = i_s_axis_tdata[16:9];

    // sequencer and RAM pipeline state
    logic              r_clr;      // reset sweep of the frame RAM
    logic [ROW_W-1:0]  r_clr_row;
    logic              r_busy;
    logic [STEP_W-1:0] r_n;        // writes for the current item
    logic [STEP_W-1:0] r_is;       // next step to read
    logic              r_dv;       // read data valid for step r_ws
    logic [STEP_W-1:0] r_ws;
    t_action           r_act;
    logic [IDX_W-1:0]  r_idx;
    logic [2:0]        r_col;
    logic              r_on;
    logic [DATA_W-1:0] r_val;

    // output register
    logic              r_ov;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;
    logic              r_last;

    logic              w_acc;
    logic [STEP_W-1:0] w_steps;
    logic              w_fire;
    logic              w_issue;
    logic              w_done;
    logic              w_is_row_op;
    logic [STEP_W-1:0] w_is_nx;
    logic [ROW_W-1:0]  w_raddr;
    logic [DATA_W-1:0] w_rdata;
    logic [ROW_W-1:0]  w_row;
    logic [DATA_W-1:0] w_px_mask;
    logic [DATA_W-1:0] w_ln_mask;
    logic              w_we;
    logic [ADDR_W-1:0] n_addr;
    logic [DATA_W-1:0] n_data;
    logic              w_ram_we;
    logic [ROW_W-1:0]  w_ram_waddr;
    logic [DATA_W-1:0] w_ram_wdata;

    assign o_s_axis_tready = !r_busy && !r_clr;
    assign w_acc = i_s_axis_tvalid && o_s_axis_tready;

    // number of writes an incoming item causes; zero means it is dropped
    always_comb begin
        case (i_s_axis_tuser) inside
            ACT_PIXEL:
                w_steps = (w_in_idx < IDX_W'(ROW_COUNT) && !w_in_col[3]) ? STEP_ONE : '0;
            ACT_ROW_BYTE:
                w_steps = (w_in_idx < IDX_W'(ROW_COUNT)) ? STEP_ONE : '0;
            ACT_LINE:
                w_steps = !w_in_idx[3] ? ROWS_N : '0;
            ACT_SCROLL, ACT_CLEAR, ACT_REFRESH:
                w_steps = ROWS_N;
            ACT_SETTINGS:
                w_steps = SETS_N;
            default:
                w_steps = '0;
        endcase
    end

    assign w_fire  = r_dv && (!r_ov || i_m_axis_tready);
    assign w_issue = r_busy && (r_is != r_n) && (!r_dv || w_fire);
    assign w_done  = w_fire && (r_ws == r_n - STEP_ONE);

    assign w_is_row_op = (r_act == ACT_PIXEL) || (r_act == ACT_ROW_BYTE);
    assign w_is_nx     = r_is + STEP_ONE;

    // scroll reads the row below the one it writes
    always_comb begin
        if (w_is_row_op) begin
            w_raddr = r_idx[ROW_W-1:0];
        end else if (r_act == ACT_SCROLL && w_is_nx < ROWS_N) begin
            w_raddr = w_is_nx[ROW_W-1:0];
        end else begin
            w_raddr = r_is[ROW_W-1:0];
        end
    end

    assign w_row     = w_is_row_op ? r_idx[ROW_W-1:0] : r_ws[ROW_W-1:0];
    assign w_px_mask = TOP_BIT >> r_col;
    assign w_ln_mask = TOP_BIT >> r_idx[2:0];

    // modify stage: read data of step r_ws is on w_rdata
    always_comb begin
        w_we   = 1'b0;
        n_addr = ADDR_W'(w_row) + ADDR_W'(1);
        n_data = w_rdata;
        unique case (r_act)
            ACT_PIXEL: begin
                w_we   = 1'b1;
                n_data = r_on ? (w_rdata | w_px_mask) : (w_rdata & ~w_px_mask);
            end
            ACT_ROW_BYTE: begin
                w_we   = 1'b1;
                n_data = r_val;
            end
            ACT_LINE: begin
                w_we   = 1'b1;
                n_data = r_val[3'd7 - r_ws[2:0]] ? (w_rdata | w_ln_mask)
                                                 : (w_rdata & ~w_ln_mask);
            end
            ACT_SCROLL: begin
                w_we   = 1'b1;
                n_data = (r_ws == ROWS_N - STEP_ONE) ? r_val : w_rdata;
            end
            ACT_CLEAR: begin
                w_we   = 1'b1;
                n_data = '0;
            end
            ACT_REFRESH: begin
                w_we   = 1'b0;
            end
            ACT_SETTINGS: begin
                case (r_ws[2:0])
                    3'd0: begin
                        n_addr = ADDR_TEST;
                        n_data = '0;
                    end
                    3'd1: begin
                        n_addr = ADDR_SCAN;
                        n_data = DATA_W'(r_scan_limit);
                    end
                    3'd2: begin
                        n_addr = ADDR_DECODE;
                        n_data = '0;
                    end
                    3'd3: begin
                        n_addr = ADDR_INTENSITY;
                        n_data = DATA_W'(r_intensity);
                    end
                    default: begin
                        n_addr = ADDR_SHUTDOWN;
                        n_data = DATA_W'(!r_shutdown_on);
                    end
                endcase
            end
            default: ;
        endcase
    end

    // RAM write port: reset sweep first, then write-back of the modify stage
    assign w_ram_we    = r_clr || (w_fire && w_we);
    assign w_ram_waddr = r_clr ? r_clr_row : w_row;
    assign w_ram_wdata = r_clr ? '0 : n_data;

    lmfcg_ram #(
        .WIDTH(DATA_W),
        .DEPTH(ROW_COUNT)
    ) u_frame_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_re   (w_issue),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_row <= '0;
            r_busy    <= 1'b0;
            r_dv      <= 1'b0;
            r_ov      <= 1'b0;
            r_n       <= '0;
            r_is      <= '0;
            r_ws      <= '0;
            r_act     <= ACT_REFRESH;
        end else begin
            if (r_clr) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
                if (r_clr_row == ROW_W'(ROW_COUNT - 1)) begin
                    r_clr <= 1'b0;
                end
            end

            if (w_acc && w_steps != '0) begin
                r_busy <= 1'b1;
                r_n    <= w_steps;
                r_is   <= '0;
                r_act  <= t_action'(i_s_axis_tuser);
                r_idx  <= w_in_idx;
                r_col  <= w_in_col[2:0];
                r_on   <= w_in_on;
                r_val  <= w_in_val;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end

            if (w_issue) begin
                r_is <= w_is_nx;
                r_ws <= r_is;
                r_dv <= 1'b1;
            end else if (w_fire) begin
                r_dv <= 1'b0;
            end

            if (w_fire) begin
                r_ov   <= 1'b1;
                r_addr <= n_addr;
                r_data <= n_data;
                r_last <= w_done;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {(M_TDATA_W - ADDR_W - DATA_W)'(0), r_data, r_addr};
    assign o_m_axis_tlast  = r_last;

endmodule

`default_nettype wire

FILE: rtl/lmfcg_checker.sv
`default_nettype none
`include "assert_macros.svh"

module lmfcg_checker
    import lmfcg_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_s_axis_tready,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input wire logic                  o_m_axis_tlast
);

    // a stalled result stays put
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
              o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast),
              "output changed while stalled")

    // no new item while the current one still has writes to give
    `AST_SAME(a_no_accept_mid_item, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast,
              !o_s_axis_tready, "input ready in the middle of an item")

    // writes of one item come back to back when the sink keeps up
    `AST_NEXT(a_burst_gapless, i_clk, i_rst_n,
              o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast,
              o_m_axis_tvalid, "gap inside a burst of writes")

    // display test is never the closing write of settings
    `AST_SAME(a_test_not_last, i_clk, i_rst_n,
              o_m_axis_tvalid && o_m_axis_tdata[ADDR_W-1:0] == ADDR_TEST,
              !o_m_axis_tlast, "display test write flagged as last")

endmodule

bind led_matrix_frame_command_gen_unit lmfcg_checker u_lmfcg_checker (.*);

`default_nettype wire

FILE: verif/led_matrix_frame_command_gen_unit_tb.sv
`timescale 1ns / 100ps

module led_matrix_frame_command_gen_unit_tb;
    import lmfcg_pkg::*;

    localparam int ROWS          = ROW_COUNT_DEF;
    localparam int N_DIRECTED    = 24;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 80;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 39;

    // tuser code with no action behind it
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_write;

    typedef struct packed {
        logic [2:0]        act;
        logic [IDX_W-1:0]  idx;
        logic [COL_W-1:0]  col;
        logic              on;
        logic [7:0]        val;
        logic              typed;
        logic [3:0]        n_writes;
        logic [ADDR_W-1:0] last_addr;
        logic [DATA_W-1:0] last_data;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]  i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    // shadow of the frame and the settings registers
    logic [7:0]       shadow_rows [ROWS];
    logic [3:0]       cfg_intensity = 4'd0;
    logic [2:0]       cfg_scan_limit = 3'd7;
    logic             cfg_shutdown_on = 1'b1;

    t_write           pending_writes [$];
    t_stim_row        table_checks [$];
    int               fail_count = 0;
    int               items_in = 0;
    int               burst_left = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{ACT_REFRESH,  4'd0,  4'd0,  1'b0, 8'h00, 1'b1, 4'd8, 4'd8, 8'h00},
        '{ACT_SETTINGS, 4'd0,  4'd0,  1'b0, 8'h00, 1'b1, 4'd5, ADDR_SHUTDOWN, 8'h00},
        '{ACT_PIXEL,    4'd0,  4'd0,  1'b1, 8'h00, 1'b1, 4'd1, 4'd1, 8'h80},
        '{ACT_PIXEL,    4'd7,  4'd7,  1'b1, 8'h00, 1'b1, 4'd1, 4'd8, 8'h01},
        '{ACT_PIXEL,    4'd7,  4'd7,  1'b0, 8'hff, 1'b1, 4'd1, 4'd8, 8'h00},
        '{ACT_PIXEL,    4'd8,  4'd0,  1'b1, 8'h00, 1'b1, 4'd0, 4'd0, 8'h00},
        '{ACT_PIXEL,    4'd3,  4'd8,  1'b1, 8'h00, 1'b1, 4'd0, 4'd0, 8'h00},
        '{ACT_PIXEL,    4'd15, 4'd15, 1'b1, 8'hff, 1'b1, 4'd0, 4'd0, 8'h00},
        '{ACT_ROW_BYTE, 4'd0,  4'd0,  1'b0, 8'hff, 1'b1, 4'd1, 4'd1, 8'hff},
        '{ACT_ROW_BYTE, 4'd7,  4'd15, 1'b1, 8'ha5, 1'b1, 4'd1, 4'd8, 8'ha5},
        '{ACT_ROW_BYTE, 4'd15, 4'd0,  1'b0, 8'h3c, 1'b1, 4'd0, 4'd0, 8'h00},
        '{ACT_ROW_BYTE, 4'd8,  4'd2,  1'b1, 8'h81, 1'b1, 4'd0, 4'd0, 8'h00},
        '{ACT_LINE,     4'd0,  4'd0,  1'b0, 8'hff, 1'b0, 4'd0, 4'd0, 8'h00},
        '{ACT_LINE,     4'd7,  4'd9,  1'b1, 8'h81, 1'b0, 4'd0, 4'd0, 8'h00},
        '{ACT_LINE,     4'd8,  4'd0,  1'b0, 8'hff, 1'b1, 4'd0, 4'd0, 8'h00},
        '{ACT_LINE,     4'd15, 4'd0,  1'b0, 8'h00, 1'b1, 4'd0, 4'd0, 8'h00},
        '{ACT_SCROLL,   4'd0,  4'd0,  1'b0, 8'h5a, 1'b0, 4'd0, 4'd0, 8'h00},
        '{ACT_SCROLL,   4'd15, 4'd15, 1'b1, 8'h00, 1'b0, 4'd0, 4'd0, 8'h00},
        '{ACT_PIXEL,    4'd2,  4'd3,  1'b0, 8'h00, 1'b0, 4'd0, 4'd0, 8'h00},
        '{ACT_PIXEL,    4'd6,  4'd4,  1'b1, 8'h00, 1'b0, 4'd0, 4'd0, 8'h00},
        '{ACT_UNUSED,   4'd15, 4'd15, 1'b1, 8'hff, 1'b1, 4'd0, 4'd0, 8'h00},
        '{ACT_CLEAR,    4'd0,  4'd0,  1'b0, 8'h00, 1'b1, 4'd8, 4'd8, 8'h00},
        '{ACT_REFRESH,  4'd0,  4'd0,  1'b0, 8'h00, 1'b1, 4'd8, 4'd8, 8'h00},
        '{ACT_SETTINGS, 4'd0,  4'd0,  1'b0, 8'h00, 1'b1, 4'd5, ADDR_SHUTDOWN, 8'h00}
    };

    led_matrix_frame_command_gen_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [3:0] index, [7:4] column, [8] pixel_on,
                                             // [16:9] value, [23:17] zero
        .i_s_axis_tuser  (i_s_axis_tuser),   // [2:0] action
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [3:0] reg_address, [11:4] reg_data
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("[led_matrix_frame_command_gen_unit] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic queue_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        pending_writes.push_back('{addr, data, 1'b0});
    endtask

    task automatic write_all_rows();
        logic [ADDR_W-1:0] addr;
        for (int r = 0; r < ROWS; r++) begin
            addr = ADDR_W'(r + 1);
            queue_write(addr, shadow_rows[r]);
        end
    endtask

    // Updates the frame shadow and queues the register writes of one command
    task automatic predict_register_writes(input logic [2:0] act, input logic [3:0] idx,
                                           input logic [3:0] col, input logic on,
                                           input logic [7:0] val);
        int     n0;
        logic [7:0] mask;
        t_write w;
        n0 = pending_writes.size();
        case (act)
            ACT_PIXEL: if (idx < ROWS && col < 8) begin
                mask = TOP_BIT >> col;
                shadow_rows[idx] = on ? (shadow_rows[idx] | mask) : (shadow_rows[idx] & ~mask);
                queue_write(idx + 4'd1, shadow_rows[idx]);
            end
            ACT_ROW_BYTE: if (idx < ROWS) begin
                shadow_rows[idx] = val;
                queue_write(idx + 4'd1, val);
            end
            ACT_LINE: if (idx < 8) begin
                mask = TOP_BIT >> idx;
                for (int r = 0; r < ROWS; r++)
                    shadow_rows[r] = val[7 - r] ? (shadow_rows[r] | mask)
                                                : (shadow_rows[r] & ~mask);
                write_all_rows();
            end
            ACT_SCROLL: begin
                for (int r = 0; r < ROWS - 1; r++)
                    shadow_rows[r] = shadow_rows[r + 1];
                shadow_rows[ROWS - 1] = val;
                write_all_rows();
            end
            ACT_CLEAR: begin
                for (int r = 0; r < ROWS; r++)
                    shadow_rows[r] = 8'h00;
                write_all_rows();
            end
            ACT_REFRESH: write_all_rows();
            ACT_SETTINGS: begin
                queue_write(ADDR_TEST, 8'h00);
                queue_write(ADDR_SCAN, {5'd0, cfg_scan_limit});
                queue_write(ADDR_DECODE, 8'h00);
                queue_write(ADDR_INTENSITY, {4'd0, cfg_intensity});
                queue_write(ADDR_SHUTDOWN, cfg_shutdown_on ? 8'h00 : 8'h01);
            end
            default: ;
        endcase
        if (pending_writes.size() > n0) begin
            w = pending_writes.pop_back();
            w.last = 1'b1;
            pending_writes.push_back(w);
        end
    endtask

    // Transaction monitor: prediction on the input side, compare on the output side
    always @(posedge i_clk) begin
        int        n0;
        t_stim_row row;
        t_write    want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_writes.size() == 0) begin
                    report_mismatch($sformatf("unexpected write addr %0d data %02h",
                                              o_m_axis_tdata[3:0], o_m_axis_tdata[11:4]));
                end else begin
                    want = pending_writes.pop_front();
                    if (o_m_axis_tdata[3:0] !== want.addr)
                        report_mismatch($sformatf("addr %0d, want %0d",
                                                  o_m_axis_tdata[3:0], want.addr));
                    if (o_m_axis_tdata[11:4] !== want.data)
                        report_mismatch($sformatf("addr %0d data %02h, want %02h",
                                                  want.addr, o_m_axis_tdata[11:4], want.data));
                    if (o_m_axis_tlast !== want.last)
                        report_mismatch($sformatf("addr %0d tlast %b, want %b",
                                                  want.addr, o_m_axis_tlast, want.last));
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                items_in++;
                n0 = pending_writes.size();
                predict_register_writes(i_s_axis_tuser, i_s_axis_tdata[3:0],
                                        i_s_axis_tdata[7:4], i_s_axis_tdata[8],
                                        i_s_axis_tdata[16:9]);
                if (table_checks.size() != 0) begin
                    row = table_checks.pop_front();
                    if (row.typed && (pending_writes.size() - n0 != row.n_writes ||
                        (row.n_writes != 0 && (pending_writes[$].addr != row.last_addr ||
                                               pending_writes[$].data != row.last_data))))
                        report_mismatch($sformatf("directed action %0d idx %0d off the table",
                                                  row.act, row.idx));
                end
            end
        end
    end

    // Output side backpressure, with one long hold once traffic is flowing
    initial begin
        int  run;
        int  mode;
        bit  hold_done;
        hold_done = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(8, 40);
            repeat (run) begin
                @(posedge i_clk);
                if (!hold_done && items_in >= HOLD_AFTER) begin
                    hold_done = 1'b1;
                    i_m_axis_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                end
                case (mode)
                    0:       i_m_axis_tready <= 1'b1;
                    1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offers one command and returns at the edge where it is taken
    task automatic send_item(input logic [2:0] act, input logic [3:0] idx,
                             input logic [3:0] col, input logic on, input logic [7:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= act;
        i_s_axis_tdata  <= {7'd0, val, on, col, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic wait_for_writes();
        int spins;
        spins = 0;
        while (pending_writes.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spins++;
        end
        if (pending_writes.size() != 0) begin
            report_mismatch($sformatf("%0d writes never arrived", pending_writes.size()));
            pending_writes.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [3:0] level, input logic [2:0] scan,
                                 input logic shut);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_INTENSITY;
        i_cfg_data <= level;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SCAN_LIMIT;
        i_cfg_data <= {1'b0, scan};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SHUTDOWN_ON;
        i_cfg_data <= {3'd0, shut};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_intensity   = level;
        cfg_scan_limit  = scan;
        cfg_shutdown_on = shut;
    endtask

    initial begin
        int         sel;
        int         done_items;
        logic [2:0] act;
        logic [3:0] idx;
        logic [3:0] col;

        for (int r = 0; r < ROWS; r++)
            shadow_rows[r] = 8'h00;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            table_checks.push_back(directed_rows[k]);
            send_item(directed_rows[k].act, directed_rows[k].idx, directed_rows[k].col,
                      directed_rows[k].on, directed_rows[k].val);
        end
        i_s_axis_tvalid <= 1'b0;
        wait_for_writes();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       load_settings(4'd15, 3'd7, 1'b0);
                1:       load_settings(4'd0, 3'd0, 1'b1);
                default: load_settings(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                                       1'($urandom_range(0, 1)));
            endcase
            send_item(ACT_SETTINGS, 4'($urandom), 4'($urandom), 1'($urandom), 8'($urandom));
            done_items = 1;
            while (done_items < PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                act = sel < 28 ? ACT_PIXEL    : sel < 46 ? ACT_ROW_BYTE :
                      sel < 60 ? ACT_LINE     : sel < 72 ? ACT_SCROLL   :
                      sel < 78 ? ACT_CLEAR    : sel < 84 ? ACT_REFRESH  :
                      sel < 90 ? ACT_SETTINGS : ACT_UNUSED;
                // mostly legal rows and columns, the odd out-of-range one as noise
                idx = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(8, 15))
                                                  : 4'($urandom_range(0, 7));
                col = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(8, 15))
                                                  : 4'($urandom_range(0, 7));
                send_item(act, idx, col, 1'($urandom), 8'($urandom));
                done_items++;
            end
            i_s_axis_tvalid <= 1'b0;
            wait_for_writes();
        end

        if (fail_count == 0)
            $display("[led_matrix_frame_command_gen_unit] OK");
        else
            $display("[led_matrix_frame_command_gen_unit] ERROR");
        $finish;
    end

endmodule
